>>> hdl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque core.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int unsigned DEPTH_DEF = 8;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned COUNT_W   = 4;

  typedef enum logic [2:0] {
    OP_INS_HEAD  = 3'd0,
    OP_INS_TAIL  = 3'd1,
    OP_REM_HEAD  = 3'd2,
    OP_REM_TAIL  = 3'd3,
    OP_PEEK_HEAD = 3'd4,
    OP_PEEK_TAIL = 3'd5
  } cdq_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } cdq_status_t;

  typedef struct packed {
    logic [2:0]               op;
    logic signed [DATA_W-1:0] value;
  } cdq_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [1:0]               status;
    logic [COUNT_W-1:0]       count;
  } cdq_out_t;

  // controller to datapath
  typedef struct packed {
    logic accept;   // item taken this cycle: update state, read store
    logic present;  // load the output register
  } cdq_cmd_t;

endpackage

>>> hdl/circular_deque_core.sv
// ----------------------------------------------------------------------------
// circular_deque_core
// Double-ended queue of DEPTH 32-bit elements in a circular store.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_ready/in_data): one request item, op and value.
//     ops: insert head, insert tail, remove head, remove tail, peek head,
//     peek tail. Codes 6 and 7 change nothing and answer ok.
//   out channel (out_valid/out_ready/out_data): exactly one result item per
//     request, with data, status (ok/overflow/underflow) and count, the
//     fill after the request modulo 16.
//   The store is read through its registered read port in the accept cycle
//   and the output register is loaded in the following execute cycle, which
//   makes the result valid. No new request is taken in the execute cycle, so
//   one request is done before the next is accepted.
//   The next request may be taken while a result still waits in the output
//   register, as long as that result is being taken in the same cycle.
//   Receiver stall: the result holds in the output register and in_ready
//   drops until it is taken.
//   Reset (rst_n low, synchronous): deque empty, head 0, tail DEPTH-1, no
//   result pending. Store contents are not cleared.
// ----------------------------------------------------------------------------
module circular_deque_core
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  cdq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output cdq_out_t out_data
);

  cdq_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  cdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

>>> hdl/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Handshake controller: accepts an item, runs the execute state, then holds
// the result in the output register until it is taken.
// ----------------------------------------------------------------------------
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output cdq_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } cdq_state_t;

  cdq_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  // the output register is free by the time the execute cycle loads it
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  assign cmd.accept  = accept;
  assign cmd.present = (state_r == S_EXEC);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (state_r == S_EXEC) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EXEC)
    else $error("no execute cycle after accept");

  a_exec_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |-> !out_valid_r)
    else $error("output register busy during execute");

  a_exec_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |=> out_valid_r)
    else $error("result not presented after execute");

endmodule

>>> hdl/cdq_dp.sv
// ----------------------------------------------------------------------------
// cdq_dp
// Deque datapath: head/tail pointers, fill count, element store and
// output register.
// ----------------------------------------------------------------------------
module cdq_dp
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  cdq_cmd_t cmd,
  input  cdq_in_t  in_data,
  output cdq_out_t out_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [FW-1:0] FULL = FW'(DEPTH);

  logic signed [DATA_W-1:0] mem [DEPTH];

  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          full, empty;
  logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          use_rd_nxt;
  logic [1:0]    status_nxt;

  logic signed [DATA_W-1:0] rd_data_r;
  logic                     use_rd_r;
  logic [1:0]               status_r;
  logic [COUNT_W-1:0]       count_r;
  logic [FW+COUNT_W-1:0]    fill_ext;
  cdq_out_t                 out_r;

  assign full  = (fill_r == FULL);
  assign empty = (fill_r == '0);

  assign head_inc = (head_r == LAST) ? '0 : head_r + AW'(1);
  assign head_dec = (head_r == '0) ? LAST : head_r - AW'(1);
  assign tail_inc = (tail_r == LAST) ? '0 : tail_r + AW'(1);
  assign tail_dec = (tail_r == '0) ? LAST : tail_r - AW'(1);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    fill_nxt   = fill_r;
    wr_en      = 1'b0;
    wr_addr    = head_dec;
    rd_addr    = head_r;
    use_rd_nxt = 1'b0;
    status_nxt = ST_OK;
    unique case (in_data.op) inside
      OP_INS_HEAD: begin
        if (full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          head_nxt = head_dec;
          wr_en    = 1'b1;
          wr_addr  = head_dec;
          fill_nxt = fill_r + FW'(1);
        end
      end
      OP_INS_TAIL: begin
        if (full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          tail_nxt = tail_inc;
          wr_en    = 1'b1;
          wr_addr  = tail_inc;
          fill_nxt = fill_r + FW'(1);
        end
      end
      OP_REM_HEAD, OP_PEEK_HEAD: begin
        if (empty) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          rd_addr    = head_r;
          use_rd_nxt = 1'b1;
          if (in_data.op == OP_REM_HEAD) begin
            head_nxt = head_inc;
            fill_nxt = fill_r - FW'(1);
          end
        end
      end
      OP_REM_TAIL, OP_PEEK_TAIL: begin
        if (empty) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          rd_addr    = tail_r;
          use_rd_nxt = 1'b1;
          if (in_data.op == OP_REM_TAIL) begin
            tail_nxt = tail_dec;
            fill_nxt = fill_r - FW'(1);
          end
        end
      end
      default: begin
        // unused op codes leave everything as is
      end
    endcase
  end

  // count is reported modulo 16
  assign fill_ext = {{COUNT_W{1'b0}}, fill_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= LAST;
      fill_r <= '0;
    end else if (cmd.accept) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) begin
      mem[wr_addr] <= in_data.value;
    end
    if (cmd.accept) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      use_rd_r <= use_rd_nxt;
      status_r <= status_nxt;
      count_r  <= fill_ext[COUNT_W-1:0];
    end
    if (cmd.present) begin
      out_r.data   <= use_rd_r ? rd_data_r : '0;
      out_r.status <= status_r;
      out_r.count  <= count_r;
    end
  end

  assign out_data = out_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL)
    else $error("fill count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> tail_r == head_dec)
    else $error("pointers disagree on empty deque");

  a_overflow_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && full &&
    (in_data.op == OP_INS_HEAD || in_data.op == OP_INS_TAIL)
    |=> $stable(fill_r) && $stable(head_r) && $stable(tail_r))
    else $error("state changed on overflowing insert");

  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && !empty &&
    (in_data.op == OP_REM_HEAD || in_data.op == OP_REM_TAIL)
    |=> fill_r == $past(fill_r) - FW'(1))
    else $error("remove did not shrink fill count");

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for circular_deque_core. A shadow model of the
// deque predicts every result item. Stimulus is a directed pass over the
// empty, full and wrap-around corners, followed by random request streams
// with shifting insert bias under several sender/receiver idling mixes and
// one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cdq_pkg::*;

  localparam int unsigned QDEPTH       = DEPTH_DEF;
  localparam int unsigned PTR_W        = $clog2(QDEPTH);
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS  = 390;
  localparam int unsigned MAX_REPORTS  = 10;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  cdq_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  cdq_out_t out_data;

  cdq_in_t  req_queue[$];     // requests waiting to be offered
  cdq_out_t expected_q[$];    // predicted results, oldest first

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_trigger   = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int mismatches     = 0;
  int quiet_cycles   = 0;

  // shadow deque
  logic signed [DATA_W-1:0] shadow_mem [QDEPTH];
  logic [PTR_W-1:0]         shadow_head;
  logic [PTR_W-1:0]         shadow_tail;
  int unsigned              shadow_fill;

  circular_deque_core #(
    .DEPTH(QDEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5ns clk = ~clk;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(QDEPTH - 1) : p - 1'b1;
  endfunction

  // apply one request to the shadow deque and return its result item
  function automatic cdq_out_t deque_step(cdq_in_t req);
    cdq_out_t res;
    logic     full;
    logic     empty;
    res   = '0;
    full  = (shadow_fill >= QDEPTH);
    empty = (shadow_fill == 0);
    case (req.op) inside
      OP_INS_HEAD: begin
        if (full) begin
          res.status = ST_OVERFLOW;
        end else begin
          shadow_head = ptr_dec(shadow_head);
          shadow_mem[shadow_head] = req.value;
          shadow_fill++;
        end
      end
      OP_INS_TAIL: begin
        if (full) begin
          res.status = ST_OVERFLOW;
        end else begin
          shadow_tail = ptr_inc(shadow_tail);
          shadow_mem[shadow_tail] = req.value;
          shadow_fill++;
        end
      end
      OP_REM_HEAD, OP_PEEK_HEAD: begin
        if (empty) begin
          res.status = ST_UNDERFLOW;
        end else begin
          res.data = shadow_mem[shadow_head];
          if (req.op == OP_REM_HEAD) begin
            shadow_head = ptr_inc(shadow_head);
            shadow_fill--;
          end
        end
      end
      OP_REM_TAIL, OP_PEEK_TAIL: begin
        if (empty) begin
          res.status = ST_UNDERFLOW;
        end else begin
          res.data = shadow_mem[shadow_tail];
          if (req.op == OP_REM_TAIL) begin
            shadow_tail = ptr_dec(shadow_tail);
            shadow_fill--;
          end
        end
      end
      default: begin
      end
    endcase
    res.count = COUNT_W'(shadow_fill);
    return res;
  endfunction

  // sender: offers the next request when the channel is free, idling at random
  always @(posedge clk) begin
    logic slot_free;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      slot_free = !in_valid || in_ready;
      if (slot_free) begin
        if (req_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= req_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on request accept, check on result accept
  always @(posedge clk) begin
    cdq_out_t want;
    if (!rst_n) begin
      shadow_head = '0;
      shadow_tail = PTR_W'(QDEPTH - 1);
      shadow_fill = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_q.push_back(deque_step(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("unexpected result item: data %0d status %0d count %0d",
                     out_data.data, out_data.status, out_data.count);
          end
        end else begin
          want = expected_q.pop_front();
          if (out_data.data !== want.data || out_data.status !== want.status ||
              out_data.count !== want.count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $write("mismatch: expected data %0d status %0d count %0d,",
                     want.data, want.status, want.count);
              $display(" got data %0d status %0d count %0d",
                       out_data.data, out_data.status, out_data.count);
            end
          end
        end
      end
    end
  end

  // watchdog on cycles with work outstanding but no handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (req_queue.size() == 0 && !in_valid && expected_q.size() == 0)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_op(logic [2:0] op, logic [DATA_W-1:0] value);
    cdq_in_t req;
    req.op    = op;
    req.value = value;
    req_queue.push_back(req);
  endtask

  // random requests; insert bias moves every 32 items so the fill level
  // sweeps between empty and full
  task automatic queue_random(int n);
    cdq_in_t req;
    int      ins_pct;
    ins_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 32 == 0) ins_pct = 15 + 35 * $urandom_range(2);
      if ($urandom_range(99) < 3) begin
        req.op = 3'(OP_PEEK_TAIL + 1 + $urandom_range(1));
      end else if ($urandom_range(99) < ins_pct) begin
        req.op = $urandom_range(1) ? OP_INS_TAIL : OP_INS_HEAD;
      end else begin
        req.op = 3'(OP_REM_HEAD + $urandom_range(3));
      end
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0: req.value = '0;
          1: req.value = '1;
          2: req.value = {1'b0, {(DATA_W-1){1'b1}}};
          default: req.value = {1'b1, {(DATA_W-1){1'b0}}};
        endcase
      end else begin
        req.value = $urandom;
      end
      req_queue.push_back(req);
    end
  endtask

  task automatic wait_idle();
    while (req_queue.size() > 0 || in_valid || expected_q.size() > 0) @(negedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty deque, including an unused op code
    queue_op(OP_REM_HEAD, $urandom);
    queue_op(OP_REM_TAIL, $urandom);
    queue_op(OP_PEEK_HEAD, $urandom);
    queue_op(OP_PEEK_TAIL, $urandom);
    queue_op(3'(OP_PEEK_TAIL + 1), $urandom);
    // fill from both ends so both pointers wrap
    queue_op(OP_INS_HEAD, 32'h7fff_ffff);
    queue_op(OP_INS_TAIL, 32'h8000_0000);
    queue_op(OP_PEEK_HEAD, '0);
    queue_op(OP_PEEK_TAIL, '0);
    queue_op(OP_INS_HEAD, 32'hffff_ffff);
    queue_op(OP_INS_TAIL, 32'h0000_0000);
    queue_op(OP_INS_HEAD, 32'h0000_0001);
    queue_op(OP_INS_TAIL, 32'h5555_5555);
    queue_op(OP_INS_HEAD, 32'haaaa_aaaa);
    queue_op(OP_INS_TAIL, 32'h0000_0002);
    // full deque
    queue_op(OP_INS_HEAD, 32'h1234_5678);
    queue_op(OP_INS_TAIL, 32'h8765_4321);
    queue_op(3'(OP_PEEK_TAIL + 2), $urandom);
    for (int i = 0; i < QDEPTH; i++) begin
      queue_op((i % 2) ? OP_REM_TAIL : OP_REM_HEAD, $urandom);
    end
    wait_idle();

    // receiver holds off while the sender keeps offering, so input backs up
    queue_random(40);
    hold_trigger++;
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      queue_random(PHASE_ITEMS);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/cdq_pkg.sv
hdl/cdq_ctrl.sv
hdl/cdq_dp.sv
hdl/circular_deque_core.sv
tb/sv/testbench.sv
